FILE: design/afpd_pkg.sv
// shared types, constants and register map for the fall pulse detector
package afpd_pkg;

  parameter int SAMPLE_BITS_DEF = 16;

  localparam int THRESH_W   = 32;
  localparam int WIDTH_W    = 8;
  localparam int HOLDOFF_W  = 8;
  localparam int PULSE_W    = 9;
  localparam int TOTAL_W    = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [PULSE_W-1:0] PULSE_MAX = '1;
  localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

  // register index, byte address is 4 * index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MAX_WIDTH = 2'd1,
    REG_HOLDOFF   = 2'd2
  } afpd_reg_e;

  typedef struct packed {
    logic               fall;
    logic               high;
    logic [TOTAL_W-1:0] total;
  } afpd_result_t;

endpackage

FILE: design/afpd_in_if.sv
// sample channel: valid/ready handshake with three signed axis fields
interface afpd_in_if #(
  parameter int SAMPLE_BITS = afpd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

FILE: design/afpd_out_if.sv
// result channel: valid/ready handshake with fall flag, level flag and count
interface afpd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           fall_detected;
  logic                           above_threshold;
  logic [afpd_pkg::TOTAL_W-1:0]   fall_total;

  modport source (output valid, fall_detected, above_threshold, fall_total, input ready);
  modport sink   (input valid, fall_detected, above_threshold, fall_total, output ready);
endinterface

FILE: design/afpd_mag.sv
// exact squared magnitude of a three-axis sample
module afpd_mag
  import afpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int MAG_W      = 2 * SAMPLE_BITS + 2
) (
  input  logic [SAMPLE_BITS-1:0] x_i,
  input  logic [SAMPLE_BITS-1:0] y_i,
  input  logic [SAMPLE_BITS-1:0] z_i,
  output logic [MAG_W-1:0]       mag_o
);

  localparam int SQ_W = 2 * SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] ONE = {{(SAMPLE_BITS-1){1'b0}}, 1'b1};

  logic [SAMPLE_BITS-1:0] ax, ay, az;
  logic [SQ_W-1:0]        sqx, sqy, sqz;

  // most negative code negates to itself, which reads as 2^(n-1) unsigned
  assign ax = x_i[SAMPLE_BITS-1] ? (~x_i + ONE) : x_i;
  assign ay = y_i[SAMPLE_BITS-1] ? (~y_i + ONE) : y_i;
  assign az = z_i[SAMPLE_BITS-1] ? (~z_i + ONE) : z_i;

  assign sqx = SQ_W'(ax) * SQ_W'(ax);
  assign sqy = SQ_W'(ay) * SQ_W'(ay);
  assign sqz = SQ_W'(az) * SQ_W'(az);

  assign mag_o = MAG_W'(sqx) + MAG_W'(sqy) + MAG_W'(sqz);

endmodule

FILE: design/afpd_track.sv
// pulse tracking, holdoff and saturating fall count
module afpd_track
  import afpd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 high_i,
  input  logic [WIDTH_W-1:0]   max_width_i,
  input  logic [HOLDOFF_W-1:0] holdoff_cfg_i,
  output afpd_result_t         result_o
);

  logic                 in_pulse_q, in_pulse_d;
  logic [PULSE_W-1:0]   len_q, len_d;
  logic [HOLDOFF_W-1:0] hold_q, hold_d, hold_load;
  logic [TOTAL_W-1:0]   cnt_q, cnt_d;
  logic                 fall;

  // a pulse closes on the first low sample
  assign fall = !high_i && in_pulse_q && (len_q <= PULSE_W'(max_width_i))
                && (hold_q == '0);

  always_comb begin
    in_pulse_d = high_i;
    len_d      = '0;
    if (high_i) begin
      if (!in_pulse_q) begin
        len_d = PULSE_W'(1);
      end else if (len_q != PULSE_MAX) begin
        len_d = len_q + PULSE_W'(1);
      end else begin
        len_d = len_q;
      end
    end
    cnt_d     = (fall && (cnt_q != COUNT_MAX)) ? cnt_q + TOTAL_W'(1) : cnt_q;
    hold_load = fall ? holdoff_cfg_i : hold_q;
    // count down includes the sample that loaded it
    hold_d    = (hold_load != '0) ? hold_load - HOLDOFF_W'(1) : '0;
  end

  assign result_o = '{fall: fall, high: high_i, total: cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pulse_q <= 1'b0;
      len_q      <= '0;
      hold_q     <= '0;
      cnt_q      <= '0;
    end else if (step_i) begin
      in_pulse_q <= in_pulse_d;
      len_q      <= len_d;
      hold_q     <= hold_d;
      cnt_q      <= cnt_d;
    end
  end

  a_len_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_pulse_q |-> (len_q == '0))
    else $error("pulse length nonzero with no open pulse");

  a_len_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pulse_q |-> (len_q != '0))
    else $error("open pulse with zero length");

  a_fall_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fall) |=> !in_pulse_q)
    else $error("pulse still open after a fall");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fall && (cnt_q != COUNT_MAX)) |=> (cnt_q == $past(cnt_q) + TOTAL_W'(1)))
    else $error("fall count did not advance");

  a_hold_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !fall && (hold_q != '0)) |=> (hold_q == $past(hold_q) - HOLDOFF_W'(1)))
    else $error("holdoff did not count down");

endmodule

FILE: design/accel_fall_pulse_detector_top.sv
// top level of the accelerometer fall pulse detector
// Takes one three-axis sample per item and returns one result item per
// sample: whether the squared magnitude x*x + y*y + z*z reaches the squared
// threshold, whether this sample closes a short pulse that counts as a fall,
// and the saturating fall count so far. The block accepts one item every
// cycle unless the result side stalls it. A sample lands in the input
// register. The three squares, the threshold compare and the pulse state
// update then run as one combinational pass into the result register, which
// offers the result item until the first rising edge where the receiver is
// ready. Each register holds its item until the next one can take it, so
// backpressure on the result side stalls the input without losing items.
// Registers are written over the APB port at byte address 4 * index
// (threshold_squared, max_pulse_width, holdoff_samples) and should only change
// while no item is in flight.
module accel_fall_pulse_detector_top
  import afpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  afpd_in_if.sink               sample_i,
  afpd_out_if.source            result_o,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic                  pready_o
);

  localparam int MAG_W = 2 * SAMPLE_BITS + 2;
  localparam int CMP_W = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;

  // configuration registers
  logic [THRESH_W-1:0]  thresh_q;
  logic [WIDTH_W-1:0]   max_width_q;
  logic [HOLDOFF_W-1:0] holdoff_q;
  logic                 cfg_wr;
  afpd_reg_e            reg_idx;

  // input and result registers
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] x_q, y_q, z_q;
  logic [MAG_W-1:0]       mag;
  logic                   out_valid_q;
  afpd_result_t           res_d, res_q;

  logic s1_ready, out_ready;
  logic high, step;

  // apb port, no wait states
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign reg_idx  = afpd_reg_e'(paddr_i[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= '0;
      max_width_q <= '0;
      holdoff_q   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THRESHOLD: thresh_q    <= pwdata_i;
        REG_MAX_WIDTH: max_width_q <= pwdata_i[WIDTH_W-1:0];
        REG_HOLDOFF:   holdoff_q   <= pwdata_i[HOLDOFF_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata_o = thresh_q;
      REG_MAX_WIDTH: prdata_o = APB_DATA_W'(max_width_q);
      REG_HOLDOFF:   prdata_o = APB_DATA_W'(holdoff_q);
      default:       prdata_o = '0;
    endcase
  end

  // a register takes a new item when empty or when its item moves on
  assign out_ready      = !out_valid_q || result_o.ready;
  assign s1_ready       = !s1_valid_q || out_ready;
  assign sample_i.ready = s1_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && sample_i.valid) begin
      x_q <= sample_i.accel_x;
      y_q <= sample_i.accel_y;
      z_q <= sample_i.accel_z;
    end
  end

  // squared magnitude of the registered sample
  afpd_mag #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mag (
    .x_i  (x_q),
    .y_i  (y_q),
    .z_i  (z_q),
    .mag_o(mag)
  );

  // threshold compare and pulse state, advanced once per item
  assign high = CMP_W'(mag) >= CMP_W'(thresh_q);
  assign step = s1_valid_q && out_ready;

  afpd_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .high_i       (high),
    .max_width_i  (max_width_q),
    .holdoff_cfg_i(holdoff_q),
    .result_o     (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.fall_detected   = res_q.fall;
  assign result_o.above_threshold = res_q.high;
  assign result_o.fall_total      = res_q.total;

endmodule
